/* rtl/dsds_pkg.sv */
package dsds_pkg;

	// input item kinds
	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	// result actions
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_NMT   = 2'd3
	} action_t;

	// sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_READ    = 3'd1,
		PH_QSTOP   = 3'd2,
		PH_DISV    = 3'd3,
		PH_SHUT    = 3'd4,
		PH_NMTWAIT = 3'd5
	} phase_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_QUICK_STOP_ENABLE   = 3'd0,
		REG_NMT_ONLY_MODE       = 3'd1,
		REG_SETTLE_TIMEOUT_MS   = 3'd2,
		REG_SHUTDOWN_TIMEOUT_MS = 3'd3,
		REG_RETRY_PERIOD_MS     = 3'd4,
		REG_RESET_SETTLE_MS     = 3'd5
	} reg_index_t;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IDX_W      = 3;

	// control words
	localparam logic [15:0] CW_QUICK_STOP      = 16'h0002;
	localparam logic [15:0] CW_DISABLE_VOLTAGE = 16'h0000;
	localparam logic [15:0] CW_SHUTDOWN        = 16'h0006;

	// status word decode
	localparam logic [15:0] SW_MASK_STATE = 16'h006F;
	localparam logic [15:0] SW_MASK_FAULT = 16'h004F;
	localparam logic [15:0] SW_OP_ENABLED = 16'h0027;
	localparam logic [15:0] SW_QS_ACTIVE  = 16'h0007;
	localparam logic [15:0] SW_FAULT_REACT = 16'h000F;

	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	// configuration reset values
	localparam logic        RST_QUICK_STOP_ENABLE   = 1'b1;
	localparam logic        RST_NMT_ONLY_MODE       = 1'b0;
	localparam logic [15:0] RST_SETTLE_TIMEOUT_MS   = 16'd400;
	localparam logic [15:0] RST_SHUTDOWN_TIMEOUT_MS = 16'd200;
	localparam logic [9:0]  RST_RETRY_PERIOD_MS     = 10'd20;
	localparam logic [9:0]  RST_RESET_SETTLE_MS     = 10'd150;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] status_word;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] control_word;
		logic        done_res;
		logic        success;
		logic        energized;
	} out_item_t;

	typedef struct packed {
		logic        quick_stop_enable;
		logic        nmt_only_mode;
		logic [15:0] settle_timeout_ms;
		logic [15:0] shutdown_timeout_ms;
		logic [9:0]  retry_period_ms;
		logic [9:0]  reset_settle_ms;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] current_command;
		logic [15:0] phase_elapsed_ms;
		logic [9:0]  retry_wait_ms;
		logic        waiting_retry;
		logic [15:0] last_status;
	} seq_state_t;

	// drive still holds power: operation enabled, quick stop active, fault reaction
	function automatic logic is_powered(input logic [15:0] sw);
		return ((sw & SW_MASK_STATE) == SW_OP_ENABLED) ||
			((sw & SW_MASK_STATE) == SW_QS_ACTIVE) ||
			((sw & SW_MASK_FAULT) == SW_FAULT_REACT);
	endfunction

endpackage

/* rtl/dsds_step.sv */
module dsds_step (
	input  dsds_pkg::seq_state_t st,
	input  dsds_pkg::cfg_t       cfg,
	input  dsds_pkg::in_item_t   item,
	output dsds_pkg::seq_state_t nxt,
	output dsds_pkg::out_item_t  res
);
	import dsds_pkg::*;

	always_comb begin
		logic        in_drive;
		logic        pwr;
		logic        qs_active;
		logic        op_enabled;
		logic [15:0] limit;
		logic [9:0]  period;
		logic [10:0] wait_inc;
		logic [15:0] elapsed_inc;
		logic [15:0] sw;

		sw          = item.status_word;
		in_drive    = (st.phase == PH_QSTOP) || (st.phase == PH_DISV) ||
			(st.phase == PH_SHUT);
		pwr         = is_powered(sw);
		qs_active   = (sw & SW_MASK_STATE) == SW_QS_ACTIVE;
		op_enabled  = (sw & SW_MASK_STATE) == SW_OP_ENABLED;
		limit       = (st.phase == PH_SHUT) ? cfg.shutdown_timeout_ms : cfg.settle_timeout_ms;
		period      = (cfg.retry_period_ms == '0) ? 10'd1 : cfg.retry_period_ms;
		wait_inc    = {1'b0, st.retry_wait_ms} + 11'd1;
		elapsed_inc = (st.phase_elapsed_ms < ELAPSED_MAX) ?
			st.phase_elapsed_ms + 16'd1 : st.phase_elapsed_ms;

		nxt              = st;
		res              = '0;
		res.action       = ACT_NONE;

		case (kind_t'(item.kind))
			// start request
			KIND_START: begin
				if (st.phase == PH_IDLE) begin
					if (cfg.nmt_only_mode) begin
						res.action   = ACT_NMT;
						res.done_res = 1'b1;
						res.success  = 1'b1;
					end else begin
						nxt.phase            = PH_READ;
						nxt.phase_elapsed_ms = '0;
						nxt.retry_wait_ms    = '0;
						nxt.waiting_retry    = 1'b0;
						res.action           = ACT_READ;
					end
				end
			end
			// status reply
			KIND_STATUS: begin
				if (st.phase == PH_READ) begin
					nxt.last_status      = sw;
					nxt.phase_elapsed_ms = '0;
					nxt.retry_wait_ms    = '0;
					nxt.waiting_retry    = 1'b0;
					if (!pwr) begin
						nxt.phase           = PH_IDLE;
						nxt.current_command = '0;
						res.done_res        = 1'b1;
						res.success         = 1'b1;
					end else begin
						res.action = ACT_WRITE;
						if (cfg.quick_stop_enable && op_enabled) begin
							nxt.phase           = PH_QSTOP;
							nxt.current_command = CW_QUICK_STOP;
						end else if (qs_active) begin
							nxt.phase           = PH_DISV;
							nxt.current_command = CW_DISABLE_VOLTAGE;
						end else begin
							nxt.phase           = PH_SHUT;
							nxt.current_command = CW_SHUTDOWN;
						end
						res.control_word = nxt.current_command;
					end
				end else if (in_drive && !st.waiting_retry) begin
					nxt.last_status = sw;
					if (!pwr || (st.phase_elapsed_ms >= limit)) begin
						// phase finished: pick the next one
						nxt.phase_elapsed_ms = '0;
						nxt.retry_wait_ms    = '0;
						nxt.waiting_retry    = 1'b0;
						if ((st.phase == PH_QSTOP) && qs_active) begin
							nxt.phase           = PH_DISV;
							nxt.current_command = CW_DISABLE_VOLTAGE;
							res.action          = ACT_WRITE;
							res.control_word    = CW_DISABLE_VOLTAGE;
						end else if ((st.phase == PH_QSTOP) || (st.phase == PH_DISV)) begin
							nxt.phase           = PH_SHUT;
							nxt.current_command = CW_SHUTDOWN;
							res.action          = ACT_WRITE;
							res.control_word    = CW_SHUTDOWN;
						end else if (!pwr) begin
							nxt.phase           = PH_IDLE;
							nxt.current_command = '0;
							res.done_res        = 1'b1;
							res.success         = 1'b1;
						end else begin
							// shutdown failed: fall back to nmt reset
							nxt.current_command = '0;
							res.action          = ACT_NMT;
							if (cfg.reset_settle_ms == '0) begin
								nxt.phase    = PH_IDLE;
								res.done_res = 1'b1;
								res.success  = 1'b1;
							end else begin
								nxt.phase = PH_NMTWAIT;
							end
						end
					end else begin
						nxt.waiting_retry = 1'b1;
						nxt.retry_wait_ms = '0;
					end
				end
			end
			// millisecond tick
			KIND_TICK: begin
				if (in_drive) begin
					nxt.phase_elapsed_ms = elapsed_inc;
					if (st.waiting_retry) begin
						if (wait_inc >= {1'b0, period}) begin
							nxt.waiting_retry = 1'b0;
							nxt.retry_wait_ms = '0;
							res.action        = ACT_WRITE;
							res.control_word  = st.current_command;
						end else begin
							nxt.retry_wait_ms = wait_inc[9:0];
						end
					end
				end else if (st.phase == PH_NMTWAIT) begin
					nxt.phase_elapsed_ms = elapsed_inc;
					if (elapsed_inc >= {6'd0, cfg.reset_settle_ms}) begin
						nxt.phase            = PH_IDLE;
						nxt.current_command  = '0;
						nxt.phase_elapsed_ms = '0;
						nxt.retry_wait_ms    = '0;
						nxt.waiting_retry    = 1'b0;
						res.done_res         = 1'b1;
						res.success          = 1'b1;
					end
				end
			end
			// access error
			default: begin
				if (st.phase != PH_IDLE) begin
					nxt.phase            = PH_IDLE;
					nxt.current_command  = '0;
					nxt.phase_elapsed_ms = '0;
					nxt.retry_wait_ms    = '0;
					nxt.waiting_retry    = 1'b0;
					res.action           = ACT_NMT;
					res.done_res         = 1'b1;
					res.success          = 1'b1;
				end
			end
		endcase

		res.energized = is_powered(nxt.last_status);
	end

endmodule

/* rtl/drive_safe_disable_sequencer.sv */
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+---------------------------------------
// in        | input     | in_valid / in_ready   | in_item: kind, status_word
// out       | output    | out_valid / out_ready | out_item: action, control_word, done_res,
//           |           |                       |   success, energized
// config    | input     | wr_en                 | wr_index, wr_data
//
// each event transfer yields exactly one result, registered in the cycle after the transfer
// sequencer state updates at each event transfer; one event per clock unless out stalls
// in_ready is high while the result register is empty or being drained, so a stalled
// output holds one result and blocks further input only until it is taken
// arst_n clears the sequencer to idle, the result register to empty, and all
// configuration registers to their defaults
module drive_safe_disable_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  dsds_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output dsds_pkg::out_item_t                 out_item,
	input  logic                                wr_en,
	input  logic [dsds_pkg::IDX_W-1:0]          wr_index,
	input  logic [dsds_pkg::CFG_DATA_W-1:0]     wr_data
);
	import dsds_pkg::*;

	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	out_item_t  res_nxt;
	out_item_t  res_q;
	logic       res_valid_q;
	logic       in_xfer;

	assign in_ready  = !res_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = res_valid_q;
	assign out_item  = res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quick_stop_enable   <= RST_QUICK_STOP_ENABLE;
			cfg_q.nmt_only_mode       <= RST_NMT_ONLY_MODE;
			cfg_q.settle_timeout_ms   <= RST_SETTLE_TIMEOUT_MS;
			cfg_q.shutdown_timeout_ms <= RST_SHUTDOWN_TIMEOUT_MS;
			cfg_q.retry_period_ms     <= RST_RETRY_PERIOD_MS;
			cfg_q.reset_settle_ms     <= RST_RESET_SETTLE_MS;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_QUICK_STOP_ENABLE:   cfg_q.quick_stop_enable   <= wr_data[0];
				REG_NMT_ONLY_MODE:       cfg_q.nmt_only_mode       <= wr_data[0];
				REG_SETTLE_TIMEOUT_MS:   cfg_q.settle_timeout_ms   <= wr_data;
				REG_SHUTDOWN_TIMEOUT_MS: cfg_q.shutdown_timeout_ms <= wr_data;
				REG_RETRY_PERIOD_MS:     cfg_q.retry_period_ms     <= wr_data[9:0];
				REG_RESET_SETTLE_MS:     cfg_q.reset_settle_ms     <= wr_data[9:0];
				default: ;
			endcase
		end
	end

	// next state and result for the incoming event
	dsds_step u_step (
		.st   (state_q),
		.cfg  (cfg_q),
		.item (in_item),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase            <= PH_IDLE;
			state_q.current_command  <= '0;
			state_q.phase_elapsed_ms <= '0;
			state_q.retry_wait_ms    <= '0;
			state_q.waiting_retry    <= 1'b0;
			state_q.last_status      <= '0;
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_xfer) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= res_nxt;
		end
	end

endmodule
